// File: rtl/pgtm_pkg.sv
package pgtm_pkg;

    localparam int NUM_FRAMES_DEF = 64;
    localparam int IDX_W          = 9;
    localparam int OFS_W          = 12;

    localparam logic [1:0] KIND_TRANSLATE = 2'd0;
    localparam logic [1:0] KIND_MAP_ADDR  = 2'd1;
    localparam logic [1:0] KIND_MAP_PAGE  = 2'd2;
    localparam logic [1:0] KIND_UNMAP     = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_MAPPED = 3'd1;
    localparam logic [2:0] ST_MISALIGNED = 3'd2;
    localparam logic [2:0] ST_NO_FRAME   = 3'd3;
    localparam logic [2:0] ST_MAPPED     = 3'd4;
    localparam logic [2:0] ST_RANGE      = 3'd5;

    localparam logic REG_HOST_BASE  = 1'b0;
    localparam logic REG_GUEST_BASE = 1'b1;

    localparam logic [1:0] PTE_FLAGS = 2'b11;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] virt_addr;
        logic [50:0] page_addr;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] host_addr;
        logic [50:0] guest_page;
    } out_t;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic        sub;
    } alu_req_t;

endpackage

// File: rtl/pgtm_alu.sv
module pgtm_alu (
    input  pgtm_pkg::alu_req_t req,
    output logic [64:0]        sum
);

    always_comb begin
        if (req.sub) begin
            sum = {1'b0, req.a} - {1'b0, req.b};
        end else begin
            sum = {1'b0, req.a} + {1'b0, req.b};
        end
    end

endmodule

// File: rtl/four_level_page_table_manager.sv
// channel | direction | handshake            | payload
// s_      | in        | s_valid / s_ready    | s_data (kind, virt_addr, page_addr)
// m_      | out       | m_valid / m_ready    | m_data (status, host_addr, guest_page)
// cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
// one operation at a time through a single shared add/sub unit and one table memory with one read and one write port
// each level passes S_RD (registered table read), then S_EV (evaluate); a missing table
// adds S_POP_RD, S_POP_EV and S_ALW (stack read, pop, entry write) and a reread of the level
// after reset a clearing pass over all NUM_FRAMES*512 table entries runs before s_ready rises
// a finished result waits in the output register while the next beat is accepted
module four_level_page_table_manager #(
    parameter int NUM_FRAMES = pgtm_pkg::NUM_FRAMES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  pgtm_pkg::in_t    s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output pgtm_pkg::out_t   m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [63:0]      cfg_data
);

    localparam int FW     = $clog2(NUM_FRAMES);
    localparam int CW     = $clog2(NUM_FRAMES + 1);
    localparam int TDEPTH = NUM_FRAMES * 512;
    localparam int TAW    = $clog2(TDEPTH);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_POP_RD = 4'd1;
    localparam logic [3:0] S_POP_EV = 4'd2;
    localparam logic [3:0] S_GPA    = 4'd3;
    localparam logic [3:0] S_ALW    = 4'd4;
    localparam logic [3:0] S_RD     = 4'd5;
    localparam logic [3:0] S_EV     = 4'd6;
    localparam logic [3:0] S_FIN    = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]            state_reg, state_next;
    logic [1:0]            kind_reg, kind_next;
    logic [47:0]           va_reg, va_next;
    logic [50:0]           pa_reg, pa_next;
    logic [1:0]            lvl_reg, lvl_next;
    logic [FW-1:0]         f_reg, f_next;
    logic [FW-1:0]         df_reg, df_next;
    logic                  popdata_reg, popdata_next;
    logic [2:0]            status_reg, status_next;
    logic [63:0]           host_reg, host_next;
    logic [50:0]           gp_reg, gp_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [NUM_FRAMES-1:0] free_reg, free_next;
    logic [TAW:0]          clr_reg, clr_next;
    pgtm_pkg::out_t        out_reg, out_next;
    logic                  mv_reg, mv_next;
    logic [63:0]           host_base_reg;
    logic [50:0]           gbase_reg;

    logic [63:0]   tbl_mem [TDEPTH];
    logic [63:0]   trd;
    logic          t_we;
    logic [TAW-1:0] t_wa, t_ra;
    logic [63:0]   t_wd;

    logic [FW-1:0] stk_mem [NUM_FRAMES];
    logic [FW-1:0] srd;
    logic          s_we;
    logic [FW-1:0] s_wa, s_ra, s_wd;

    pgtm_pkg::alu_req_t alu_req;
    logic [64:0]        alu_sum;

    logic          clr_done;
    logic [8:0]    idx;
    logic [CW-1:0] cnt_dec;
    logic          e_ok;
    logic          push_en;
    logic [FW-1:0] push_f;
    logic          misal;

    pgtm_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    assign clr_done  = (clr_reg == (TAW+1)'(TDEPTH));
    assign s_ready   = (state_reg == S_IDLE) && clr_done;
    assign m_valid   = mv_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;
    assign cnt_dec   = cnt_reg - CW'(1);
    assign s_ra      = cnt_dec[FW-1:0];
    assign t_ra      = {f_reg, idx};
    assign e_ok      = !alu_sum[64] && (alu_sum[63:0] < 64'(NUM_FRAMES));

    always_comb begin
        case (lvl_reg)
            2'd0:    idx = va_reg[47:39];
            2'd1:    idx = va_reg[38:30];
            2'd2:    idx = va_reg[29:21];
            default: idx = va_reg[20:12];
        endcase
    end

    always_comb begin
        misal = (s_data.virt_addr[11:0] != 12'd0);
        if (s_data.kind == pgtm_pkg::KIND_MAP_ADDR) begin
            misal = misal || (s_data.page_addr[11:0] != 12'd0);
        end
    end

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        va_next      = va_reg;
        pa_next      = pa_reg;
        lvl_next     = lvl_reg;
        f_next       = f_reg;
        df_next      = df_reg;
        popdata_next = popdata_reg;
        status_next  = status_reg;
        host_next    = host_reg;
        gp_next      = gp_reg;
        cnt_next     = cnt_reg;
        free_next    = free_reg;
        clr_next     = clr_reg;
        out_next     = out_reg;
        mv_next      = mv_reg;
        t_we         = 1'b0;
        t_wa         = t_ra;
        t_wd         = 64'd0;
        s_we         = 1'b0;
        s_wa         = cnt_reg[FW-1:0];
        s_wd         = '0;
        push_en      = 1'b0;
        push_f       = df_reg;
        alu_req.a    = 64'(trd[50:12]);
        alu_req.b    = 64'(gbase_reg[50:12]);
        alu_req.sub  = 1'b1;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        if (!clr_done) begin
            clr_next = clr_reg + (TAW+1)'(1);
            t_we     = 1'b1;
            t_wa     = clr_reg[TAW-1:0];
            if (clr_reg < (TAW+1)'(NUM_FRAMES)) begin
                s_we = 1'b1;
                s_wa = clr_reg[FW-1:0];
                s_wd = FW'(NUM_FRAMES - 1) - clr_reg[FW-1:0];
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    kind_next    = s_data.kind;
                    va_next      = s_data.virt_addr;
                    pa_next      = s_data.page_addr;
                    lvl_next     = 2'd0;
                    f_next       = '0;
                    popdata_next = 1'b0;
                    status_next  = pgtm_pkg::ST_OK;
                    host_next    = 64'd0;
                    gp_next      = 51'd0;
                    if (s_data.kind != pgtm_pkg::KIND_TRANSLATE && misal) begin
                        status_next = pgtm_pkg::ST_MISALIGNED;
                        state_next  = S_DONE;
                    end else if (s_data.kind == pgtm_pkg::KIND_MAP_PAGE) begin
                        if (cnt_reg == '0) begin
                            status_next = pgtm_pkg::ST_NO_FRAME;
                            state_next  = S_DONE;
                        end else begin
                            popdata_next = 1'b1;
                            state_next   = S_POP_RD;
                        end
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_POP_RD: begin
                state_next = S_POP_EV;
            end
            S_POP_EV: begin
                cnt_next       = cnt_dec;
                free_next[srd] = 1'b0;
                df_next        = popdata_reg ? srd : df_reg;
                push_f         = srd;
                popdata_next   = 1'b0;
                state_next     = popdata_reg ? S_GPA : S_ALW;
                f_next         = f_reg;
                if (!popdata_reg) begin
                    df_next = df_reg;
                end
                pa_next = pa_reg;
                gp_next = gp_reg;
                host_next = host_reg;
                // new frame number held in the stack read register for the next state
            end
            S_GPA: begin
                alu_req.a   = 64'(gbase_reg[50:12]);
                alu_req.b   = 64'(df_reg);
                alu_req.sub = 1'b0;
                pa_next     = {alu_sum[38:0], 12'd0};
                gp_next     = {alu_sum[38:0], 12'd0};
                state_next  = S_RD;
            end
            S_ALW: begin
                alu_req.a   = 64'(gbase_reg[50:12]);
                alu_req.b   = 64'(srd);
                alu_req.sub = 1'b0;
                t_we        = 1'b1;
                t_wa        = t_ra;
                t_wd        = {13'd0, alu_sum[38:0], 10'd0, pgtm_pkg::PTE_FLAGS};
                state_next  = S_RD;
            end
            S_RD: begin
                state_next = S_EV;
            end
            S_EV: begin
                case (kind_reg)
                    pgtm_pkg::KIND_TRANSLATE: begin
                        if ((lvl_reg != 2'd3 && trd == 64'd0) ||
                            (lvl_reg == 2'd3 && !trd[0])) begin
                            status_next = pgtm_pkg::ST_NOT_MAPPED;
                            state_next  = S_DONE;
                        end else if (!e_ok) begin
                            status_next = pgtm_pkg::ST_RANGE;
                            state_next  = S_DONE;
                        end else begin
                            f_next = alu_sum[FW-1:0];
                            if (lvl_reg == 2'd3) begin
                                state_next = S_FIN;
                            end else begin
                                lvl_next   = lvl_reg + 2'd1;
                                state_next = S_RD;
                            end
                        end
                    end
                    pgtm_pkg::KIND_UNMAP: begin
                        if (!trd[0]) begin
                            status_next = pgtm_pkg::ST_NOT_MAPPED;
                            state_next  = S_DONE;
                        end else if (lvl_reg == 2'd3) begin
                            push_en    = e_ok;
                            push_f     = alu_sum[FW-1:0];
                            t_we       = 1'b1;
                            t_wa       = t_ra;
                            t_wd       = 64'd0;
                            state_next = S_DONE;
                        end else if (!e_ok) begin
                            status_next = pgtm_pkg::ST_RANGE;
                            state_next  = S_DONE;
                        end else begin
                            f_next     = alu_sum[FW-1:0];
                            lvl_next   = lvl_reg + 2'd1;
                            state_next = S_RD;
                        end
                    end
                    default: begin
                        if (lvl_reg == 2'd3) begin
                            if (trd != 64'd0) begin
                                status_next = pgtm_pkg::ST_MAPPED;
                                state_next  = S_DONE;
                            end else begin
                                t_we = 1'b1;
                                t_wa = t_ra;
                                t_wd = {13'd0, pa_reg[50:12], 10'd0, pgtm_pkg::PTE_FLAGS};
                                state_next = (kind_reg == pgtm_pkg::KIND_MAP_PAGE) ?
                                             S_FIN : S_DONE;
                            end
                        end else if (trd == 64'd0) begin
                            if (cnt_reg == '0) begin
                                status_next = pgtm_pkg::ST_NO_FRAME;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_POP_RD;
                            end
                        end else if (!e_ok) begin
                            status_next = pgtm_pkg::ST_RANGE;
                            state_next  = S_DONE;
                        end else begin
                            f_next     = alu_sum[FW-1:0];
                            lvl_next   = lvl_reg + 2'd1;
                            state_next = S_RD;
                        end
                        // failed allocate-and-map gives its data frame back
                        if (kind_reg == pgtm_pkg::KIND_MAP_PAGE && state_next == S_DONE &&
                            status_next != pgtm_pkg::ST_OK) begin
                            push_en = 1'b1;
                            push_f  = df_reg;
                            gp_next = 51'd0;
                        end
                    end
                endcase
            end
            S_FIN: begin
                alu_req.a   = host_base_reg;
                alu_req.sub = 1'b0;
                if (kind_reg == pgtm_pkg::KIND_TRANSLATE) begin
                    alu_req.b = 64'({f_reg, va_reg[11:0]});
                end else begin
                    alu_req.b = 64'({df_reg, 12'd0});
                end
                host_next  = alu_sum[63:0];
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!mv_reg || m_ready) begin
                    out_next.status     = status_reg;
                    out_next.host_addr  = host_reg;
                    out_next.guest_page = gp_reg;
                    mv_next             = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (push_en && !free_reg[push_f] && cnt_reg < CW'(NUM_FRAMES)) begin
            s_we              = 1'b1;
            s_wa              = cnt_reg[FW-1:0];
            s_wd              = push_f;
            cnt_next          = cnt_reg + CW'(1);
            free_next[push_f] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (t_we) begin
            tbl_mem[t_wa] <= t_wd;
        end
        trd <= tbl_mem[t_ra];
    end

    always_ff @(posedge aclk) begin
        if (s_we) begin
            stk_mem[s_wa] <= s_wd;
        end
        srd <= stk_mem[s_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            popdata_reg   <= 1'b0;
            cnt_reg       <= CW'(NUM_FRAMES - 1);
            free_reg      <= {{(NUM_FRAMES-1){1'b1}}, 1'b0};
            clr_reg       <= '0;
            mv_reg        <= 1'b0;
            host_base_reg <= 64'd0;
            gbase_reg     <= 51'd0;
        end else begin
            state_reg   <= state_next;
            popdata_reg <= popdata_next;
            cnt_reg     <= cnt_next;
            free_reg    <= free_next;
            clr_reg     <= clr_next;
            mv_reg      <= mv_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == pgtm_pkg::REG_HOST_BASE) begin
                    host_base_reg <= cfg_data;
                end else begin
                    gbase_reg <= cfg_data[50:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        va_reg     <= va_next;
        pa_reg     <= pa_next;
        lvl_reg    <= lvl_next;
        f_reg      <= f_next;
        df_reg     <= df_next;
        status_reg <= status_next;
        host_reg   <= host_next;
        gp_reg     <= gp_next;
        out_reg    <= out_next;
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(NUM_FRAMES))
        else $error("free count above frame count");

    a_free_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(free_reg) == int'(cnt_reg))
        else $error("free bits disagree with free count");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready while an operation runs");

endmodule

// File: verif/testbench.sv
module testbench;

    localparam int NF = pgtm_pkg::NUM_FRAMES_DEF;
    localparam longint unsigned CYCLE_LIMIT = 2000000;
    localparam logic [63:0] ADDR_MASK = 64'h7FFFFFFFFF000;
    localparam logic [63:0] G51_MASK = 64'h7FFFFFFFFFFFF;

    class page_table_scoreboard;
        logic [63:0] tbl [0:NF*512-1];
        logic [5:0] stk [0:NF-1];
        int cnt;
        bit is_free [0:NF-1];
        logic [63:0] host_base;
        logic [63:0] guest_base;
        pgtm_pkg::out_t exp_q[$];
        int errors;

        function new();
            for (int i = 0; i < NF*512; i++) tbl[i] = '0;
            for (int i = 0; i < NF - 1; i++) stk[i] = 6'(NF - 1 - i);
            stk[NF-1] = '0;
            cnt = NF - 1;
            for (int i = 0; i < NF; i++) is_free[i] = (i != 0);
            host_base = '0;
            guest_base = '0;
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic [63:0] d);
            if (idx == pgtm_pkg::REG_HOST_BASE) host_base = d;
            else guest_base = d & G51_MASK;
        endfunction

        function logic [63:0] page_base();
            return guest_base & ADDR_MASK;
        endfunction

        function bit frame_of(logic [63:0] e, output int f);
            logic [63:0] pa, d;
            pa = e & ADDR_MASK;
            f = 0;
            if (pa < page_base()) return 0;
            d = (pa - page_base()) >> 12;
            if (d >= NF) return 0;
            f = int'(d);
            return 1;
        endfunction

        function logic [63:0] guest_addr(int f);
            return (page_base() + 64'(f) * 4096) & G51_MASK;
        endfunction

        function logic [63:0] host_addr(int f);
            return host_base + 64'(f) * 4096;
        endfunction

        function int slot(int f, logic [47:0] va, int lvl);
            return f * 512 + int'((va >> (39 - 9 * lvl)) & 48'h1FF);
        endfunction

        function bit pop(output int f);
            f = 0;
            if (cnt == 0) return 0;
            cnt--;
            f = stk[cnt];
            is_free[f] = 0;
            return 1;
        endfunction

        function void push(int f);
            if (f >= NF || is_free[f] || cnt >= NF) return;
            stk[cnt] = 6'(f);
            cnt++;
            is_free[f] = 1;
        endfunction

        function logic [2:0] map_walk(logic [47:0] va, logic [63:0] pa);
            int f, nf, s;
            f = 0;
            for (int lvl = 0; lvl < 3; lvl++) begin
                s = slot(f, va, lvl);
                if (tbl[s] == 0) begin
                    if (!pop(nf)) return pgtm_pkg::ST_NO_FRAME;
                    tbl[s] = guest_addr(nf) | 64'(pgtm_pkg::PTE_FLAGS);
                end
                if (!frame_of(tbl[s], f)) return pgtm_pkg::ST_RANGE;
            end
            s = slot(f, va, 3);
            if (tbl[s] != 0) return pgtm_pkg::ST_MAPPED;
            tbl[s] = (pa & G51_MASK) | 64'(pgtm_pkg::PTE_FLAGS);
            return pgtm_pkg::ST_OK;
        endfunction

        function void note(pgtm_pkg::in_t x);
            pgtm_pkg::out_t r;
            int f, df, s;
            logic [63:0] e;
            r = '0;
            f = 0;
            case (x.kind)
                pgtm_pkg::KIND_TRANSLATE: begin
                    for (int lvl = 0; lvl < 4; lvl++) begin
                        e = tbl[slot(f, x.virt_addr, lvl)];
                        if ((lvl < 3 && e == 0) || (lvl == 3 && !e[0])) begin
                            r.status = pgtm_pkg::ST_NOT_MAPPED;
                            break;
                        end
                        if (!frame_of(e, f)) begin
                            r.status = pgtm_pkg::ST_RANGE;
                            break;
                        end
                    end
                    if (r.status == pgtm_pkg::ST_OK)
                        r.host_addr = host_addr(f) + 64'(x.virt_addr[11:0]);
                end
                pgtm_pkg::KIND_MAP_ADDR: begin
                    if (x.virt_addr[11:0] != 0 || x.page_addr[11:0] != 0)
                        r.status = pgtm_pkg::ST_MISALIGNED;
                    else
                        r.status = map_walk(x.virt_addr, 64'(x.page_addr));
                end
                pgtm_pkg::KIND_MAP_PAGE: begin
                    if (x.virt_addr[11:0] != 0) r.status = pgtm_pkg::ST_MISALIGNED;
                    else if (!pop(df)) r.status = pgtm_pkg::ST_NO_FRAME;
                    else begin
                        r.status = map_walk(x.virt_addr, guest_addr(df));
                        if (r.status == pgtm_pkg::ST_OK) begin
                            r.host_addr = host_addr(df);
                            r.guest_page = 51'(guest_addr(df));
                        end else begin
                            push(df);
                        end
                    end
                end
                default: begin
                    if (x.virt_addr[11:0] != 0) r.status = pgtm_pkg::ST_MISALIGNED;
                    else begin
                        for (int lvl = 0; lvl < 4; lvl++) begin
                            s = slot(f, x.virt_addr, lvl);
                            e = tbl[s];
                            if (!e[0]) begin
                                r.status = pgtm_pkg::ST_NOT_MAPPED;
                                break;
                            end
                            if (lvl == 3) begin
                                if (frame_of(e, f)) push(f);
                                tbl[s] = '0;
                                break;
                            end
                            if (!frame_of(e, f)) begin
                                r.status = pgtm_pkg::ST_RANGE;
                                break;
                            end
                        end
                    end
                end
            endcase
            exp_q.push_back(r);
        endfunction

        function void check(pgtm_pkg::out_t got);
            pgtm_pkg::out_t w;
            if (exp_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat: %p", got);
                return;
            end
            w = exp_q.pop_front();
            if (got.status !== w.status || got.host_addr !== w.host_addr ||
                got.guest_page !== w.guest_page) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected status %0d host %h guest %h, got %0d %h %h",
                             w.status, w.host_addr, w.guest_page,
                             got.status, got.host_addr, got.guest_page);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    pgtm_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    pgtm_pkg::out_t m_data;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic cfg_index = pgtm_pkg::REG_HOST_BASE;
    logic [63:0] cfg_data = '0;

    page_table_scoreboard sb = new();
    longint unsigned cycles = 0;

    four_level_page_table_manager i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stalls: steps through four modes (always ready, mostly ready, mostly stalled, periodic)
    always @(negedge aclk) begin
        case ((cycles / 300) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ((cycles % 7) > 2);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check(m_data);
    end

    task automatic write_cfg(logic idx, logic [63:0] d);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, d);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // call at a falling edge; returns at a falling edge with valid still high
    task automatic put(pgtm_pkg::in_t x);
        s_valid <= 1'b1;
        s_data <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note(x);
        @(negedge aclk);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.exp_q.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic logic [47:0] pick_va();
        logic [47:0] va;
        if ($urandom_range(0, 9) == 0) return 48'({$urandom(), $urandom()});
        for (int l = 0; l < 4; l++) begin
            case ($urandom_range(0, 3))
                0: va[47 - 9*l -: 9] = 9'd0;
                1: va[47 - 9*l -: 9] = 9'h1FF;
                2: va[47 - 9*l -: 9] = 9'(l);
                default: va[47 - 9*l -: 9] = 9'($urandom_range(0, 3));
            endcase
        end
        va[11:0] = ($urandom_range(0, 5) == 0) ? 12'($urandom()) : 12'd0;
        return va;
    endfunction

    function automatic pgtm_pkg::in_t pick_item();
        pgtm_pkg::in_t x;
        int w;
        x.virt_addr = pick_va();
        x.page_addr = 51'({$urandom(), $urandom()});
        w = $urandom_range(0, 99);
        if (w < 30) x.kind = pgtm_pkg::KIND_TRANSLATE;
        else if (w < 45) x.kind = pgtm_pkg::KIND_MAP_ADDR;
        else if (w < 75) x.kind = pgtm_pkg::KIND_MAP_PAGE;
        else x.kind = pgtm_pkg::KIND_UNMAP;
        if (x.kind == pgtm_pkg::KIND_MAP_ADDR) begin
            w = $urandom_range(0, 9);
            if (w < 5) x.page_addr = 51'(sb.guest_addr($urandom_range(0, NF + 6)));
            else if (w < 9) x.page_addr[11:0] = '0;
        end
        return x;
    endfunction

    task automatic random_phase(int n);
        int done;
        int blen;
        done = 0;
        @(negedge aclk);
        while (done < n) begin
            blen = $urandom_range(1, 24);
            for (int i = 0; i < blen && done < n; i++) begin
                put(pick_item());
                done++;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
        end
    endtask

    task automatic directed();
        pgtm_pkg::in_t x;
        logic [47:0] vas [0:13];
        logic [1:0] kinds [0:13];
        logic [50:0] pas [0:13];
        vas = '{48'h0, 48'h0, 48'hFFF, 48'hFFFFFFFFF000, 48'hFFFFFFFFF000, 48'h1234,
                48'h2000, 48'h0, 48'hFFFFFFFFFFFF, 48'h5001, 48'h0, 48'h0,
                48'hFFFFFFFFF000, 48'hFFFFFFFFF000};
        kinds = '{pgtm_pkg::KIND_TRANSLATE, pgtm_pkg::KIND_MAP_PAGE,
                  pgtm_pkg::KIND_TRANSLATE, pgtm_pkg::KIND_MAP_ADDR,
                  pgtm_pkg::KIND_TRANSLATE, pgtm_pkg::KIND_MAP_ADDR,
                  pgtm_pkg::KIND_MAP_ADDR, pgtm_pkg::KIND_MAP_ADDR,
                  pgtm_pkg::KIND_MAP_PAGE, pgtm_pkg::KIND_UNMAP,
                  pgtm_pkg::KIND_UNMAP, pgtm_pkg::KIND_UNMAP,
                  pgtm_pkg::KIND_UNMAP, pgtm_pkg::KIND_TRANSLATE};
        pas = '{51'h0, 51'h0, 51'h0, 51'h7FFFFFFFFF000, 51'h0, 51'h0,
                51'h7FFFFFFFFFFFF, 51'h3000, 51'h0, 51'h0, 51'h0, 51'h0,
                51'h0, 51'h0};
        @(negedge aclk);
        for (int i = 0; i < 14; i++) begin
            x.kind = kinds[i];
            x.virt_addr = vas[i];
            x.page_addr = pas[i];
            put(x);
        end
        // exhaust the free stack
        for (int i = 0; i < 20; i++) begin
            x.kind = pgtm_pkg::KIND_MAP_PAGE;
            x.virt_addr = {9'(i), 9'(i), 9'd7, 9'(i), 12'd0};
            x.page_addr = '0;
            put(x);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        write_cfg(pgtm_pkg::REG_HOST_BASE, 64'h0);
        write_cfg(pgtm_pkg::REG_GUEST_BASE, 64'h0);
        directed();
        drain();
        random_phase(300);
        drain();
        write_cfg(pgtm_pkg::REG_HOST_BASE, 64'hFFFFFFFFFFFFFFFF);
        write_cfg(pgtm_pkg::REG_GUEST_BASE, 64'hFFFFFFFFFFFFFFFF);
        random_phase(200);
        drain();
        write_cfg(pgtm_pkg::REG_HOST_BASE, {$urandom(), $urandom()});
        write_cfg(pgtm_pkg::REG_GUEST_BASE, {$urandom(), 20'h0, 12'($urandom())});
        random_phase(250);
        drain();
        write_cfg(pgtm_pkg::REG_HOST_BASE, {$urandom(), $urandom()});
        write_cfg(pgtm_pkg::REG_GUEST_BASE, 64'h0);
        random_phase(370);
        drain();
        if (sb.errors == 0 && sb.exp_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/pgtm_pkg.sv
rtl/pgtm_alu.sv
rtl/four_level_page_table_manager.sv
verif/testbench.sv
